/* hdl/event_priority_queue_macros.svh */
// Assertion macros used by the checker of the event priority queue.
`ifndef EVENT_PRIORITY_QUEUE_MACROS_SVH
`define EVENT_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define EPQ_ASSERT_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("event priority queue check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define EPQ_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("event priority queue check failed");

`endif

/* hdl/epq_pkg.sv */
// ----------------------------------------------------------------------------
// Event priority queue package
// Shared constants, codes and types of the event priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package epq_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 64;
   localparam int TIME_BITS_DEFAULT   = 32;
   localparam int TAG_BITS_DEFAULT    = 16;

   localparam int CMD_BITS    = 2;
   localparam int STATUS_BITS = 3;
   localparam int SEQ_BITS    = 32;

   localparam logic [CMD_BITS-1:0] CMD_SCHEDULE = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_POP      = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_EXECUTE  = 2'd2;

   localparam logic [STATUS_BITS-1:0] STATUS_OK          = 3'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_PAST        = 3'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL        = 3'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY       = 3'd3;
   localparam logic [STATUS_BITS-1:0] STATUS_NOT_CURRENT = 3'd4;

   // Operation applied to every cell of the chain in the same cycle.
   typedef struct packed {
      logic insert;
      logic pop;
   } chain_ctl_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

endpackage

`default_nettype wire

/* hdl/epq_cell.sv */
// ----------------------------------------------------------------------------
// Event priority queue cell
// One slot of the sorted chain; shifts right on insert and left on pop.
// ----------------------------------------------------------------------------
`default_nettype none

module epq_cell #(
   parameter int TIME_BITS = epq_pkg::TIME_BITS_DEFAULT,
   parameter int TAG_BITS  = epq_pkg::TAG_BITS_DEFAULT
) (
   input  wire                           clock,
   input  wire                           reset,
   input  epq_pkg::chain_ctl_type        ctl,
   input  wire  [TIME_BITS-1:0]          new_time,
   input  wire  [epq_pkg::SEQ_BITS-1:0]  new_seq,
   input  wire  [TAG_BITS-1:0]           new_tag,
   input  wire                           left_before,
   input  wire                           left_valid,
   input  wire  [TIME_BITS-1:0]          left_time,
   input  wire  [epq_pkg::SEQ_BITS-1:0]  left_seq,
   input  wire  [TAG_BITS-1:0]           left_tag,
   input  wire                           right_valid,
   input  wire  [TIME_BITS-1:0]          right_time,
   input  wire  [epq_pkg::SEQ_BITS-1:0]  right_seq,
   input  wire  [TAG_BITS-1:0]           right_tag,
   output logic                          new_before,
   output logic                          ent_valid,
   output logic [TIME_BITS-1:0]          ent_time,
   output logic [epq_pkg::SEQ_BITS-1:0]  ent_seq,
   output logic [TAG_BITS-1:0]           ent_tag
);

   logic                         valid_ff, valid_in;
   logic [TIME_BITS-1:0]         time_ff, time_in;
   logic [epq_pkg::SEQ_BITS-1:0] seq_ff, seq_in;
   logic [TAG_BITS-1:0]          tag_ff, tag_in;

   // An empty slot sorts after everything, so the chain stays packed at the head.
   assign new_before = !valid_ff || (new_time < time_ff) ||
                       ((new_time == time_ff) && (new_seq < seq_ff));

   always_comb begin
      valid_in = valid_ff;
      time_in  = time_ff;
      seq_in   = seq_ff;
      tag_in   = tag_ff;
      if (ctl.insert && new_before) begin
         if (left_before) begin
            valid_in = left_valid;
            time_in  = left_time;
            seq_in   = left_seq;
            tag_in   = left_tag;
         end else begin
            valid_in = 1'b1;
            time_in  = new_time;
            seq_in   = new_seq;
            tag_in   = new_tag;
         end
      end else if (ctl.pop) begin
         valid_in = right_valid;
         time_in  = right_time;
         seq_in   = right_seq;
         tag_in   = right_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      time_ff <= time_in;
      seq_ff  <= seq_in;
      tag_ff  <= tag_in;
   end

   assign ent_valid = valid_ff;
   assign ent_time  = time_ff;
   assign ent_seq   = seq_ff;
   assign ent_tag   = tag_ff;

endmodule

`default_nettype wire

/* hdl/event_priority_queue.sv */
// A request is first captured into the held request registers; the response is registered from
// them once no earlier response is still waiting on the consumer.
// One request at a time: the block accepts a request in S_IDLE, and in S_EXEC the cell chain
// takes its single compare-and-shift step while the response is registered; only then is the
// next request taken. A response held back by the consumer stalls the block until it is taken.
// Reset is synchronous and active high; it empties the chain and clears time and sequence.
// ----------------------------------------------------------------------------
// Event priority queue
// Discrete-event scheduler kept as a sorted chain of cells, earliest event at the head.
// ----------------------------------------------------------------------------
`default_nettype none

module event_priority_queue #(
   parameter int QUEUE_DEPTH = epq_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int TIME_BITS   = epq_pkg::TIME_BITS_DEFAULT,
   parameter int TAG_BITS    = epq_pkg::TAG_BITS_DEFAULT,
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1),
   localparam int REQ_BITS   = epq_pkg::CMD_BITS + TIME_BITS + TAG_BITS,
   localparam int REQ_DATA_BITS = ((REQ_BITS + 7) / 8) * 8,
   localparam int RSP_BITS   = epq_pkg::STATUS_BITS + TAG_BITS + 2 * TIME_BITS +
                               epq_pkg::SEQ_BITS + COUNT_BITS,
   localparam int RSP_DATA_BITS = ((RSP_BITS + 7) / 8) * 8
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_tvalid,
   output logic                     req_tready,
   // command, event_time, event_tag (lowest bits first)
   input  wire  [REQ_DATA_BITS-1:0] req_tdata,
   output logic                     rsp_tvalid,
   input  wire                      rsp_tready,
   // status, out_tag, out_time, out_sequence, queue_count, now_time (lowest bits first)
   output logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   localparam int SEQ_BITS = epq_pkg::SEQ_BITS;

   epq_pkg::state_type              state_ff, state_in;
   logic [epq_pkg::CMD_BITS-1:0]    cmd_ff, cmd_in;
   logic [TIME_BITS-1:0]            req_time_ff, req_time_in;
   logic [TAG_BITS-1:0]             req_tag_ff, req_tag_in;
   logic [COUNT_BITS-1:0]           count_ff, count_in;
   logic [TIME_BITS-1:0]            now_ff, now_in;
   logic [SEQ_BITS-1:0]             next_seq_ff, next_seq_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0]        rsp_data_ff, rsp_data_in;

   logic                            commit;
   epq_pkg::chain_ctl_type          ctl;
   logic [epq_pkg::STATUS_BITS-1:0] status;
   logic [TAG_BITS-1:0]             out_tag;
   logic [TIME_BITS-1:0]            out_time;
   logic [SEQ_BITS-1:0]             out_seq;

   logic                            c_before [QUEUE_DEPTH];
   logic                            c_valid  [QUEUE_DEPTH];
   logic [TIME_BITS-1:0]            c_time   [QUEUE_DEPTH];
   logic [SEQ_BITS-1:0]             c_seq    [QUEUE_DEPTH];
   logic [TAG_BITS-1:0]             c_tag    [QUEUE_DEPTH];

   assign req_tready = (state_ff == epq_pkg::S_IDLE);
   assign commit     = (state_ff == epq_pkg::S_EXEC) && (!rsp_valid_ff || rsp_tready);

   // Decision for the held request; the chain moves only in the cycle it commits.
   always_comb begin
      ctl         = '0;
      status      = epq_pkg::STATUS_OK;
      out_tag     = '0;
      out_time    = '0;
      out_seq     = '0;
      count_in    = count_ff;
      now_in      = now_ff;
      next_seq_in = next_seq_ff;
      unique case (cmd_ff)
         epq_pkg::CMD_SCHEDULE: begin
            if (req_time_ff < now_ff) begin
               status = epq_pkg::STATUS_PAST;
            end else if (count_ff == COUNT_BITS'(QUEUE_DEPTH)) begin
               status = epq_pkg::STATUS_FULL;
            end else begin
               ctl.insert  = commit;
               out_tag     = req_tag_ff;
               out_time    = req_time_ff;
               out_seq     = next_seq_ff;
               count_in    = count_ff + COUNT_BITS'(1);
               next_seq_in = next_seq_ff + SEQ_BITS'(1);
            end
         end
         epq_pkg::CMD_POP: begin
            if (count_ff == '0) begin
               status = epq_pkg::STATUS_EMPTY;
            end else begin
               ctl.pop  = commit;
               out_tag  = c_tag[0];
               out_time = c_time[0];
               out_seq  = c_seq[0];
               count_in = count_ff - COUNT_BITS'(1);
               now_in   = c_time[0];
            end
         end
         epq_pkg::CMD_EXECUTE: begin
            if (req_time_ff != now_ff) begin
               status = epq_pkg::STATUS_NOT_CURRENT;
            end else begin
               out_tag     = req_tag_ff;
               out_time    = req_time_ff;
               out_seq     = next_seq_ff;
               next_seq_in = next_seq_ff + SEQ_BITS'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      req_time_in  = req_time_ff;
      req_tag_in   = req_tag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         epq_pkg::S_IDLE: begin
            if (req_tvalid) begin
               cmd_in      = req_tdata[epq_pkg::CMD_BITS-1:0];
               req_time_in = req_tdata[epq_pkg::CMD_BITS +: TIME_BITS];
               req_tag_in  = req_tdata[epq_pkg::CMD_BITS + TIME_BITS +: TAG_BITS];
               state_in    = epq_pkg::S_EXEC;
            end
         end
         epq_pkg::S_EXEC: begin
            if (commit) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_BITS'({now_in, count_in, out_seq, out_time,
                                              out_tag, status});
               state_in     = epq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = epq_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= epq_pkg::S_IDLE;
         count_ff     <= '0;
         now_ff       <= '0;
         next_seq_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (commit) begin
            count_ff    <= count_in;
            now_ff      <= now_in;
            next_seq_ff <= next_seq_in;
         end
      end
      cmd_ff      <= cmd_in;
      req_time_ff <= req_time_in;
      req_tag_ff  <= req_tag_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      logic                 l_before, l_valid, r_valid;
      logic [TIME_BITS-1:0] l_time, r_time;
      logic [SEQ_BITS-1:0]  l_seq, r_seq;
      logic [TAG_BITS-1:0]  l_tag, r_tag;

      if (g == 0) begin : g_head
         assign l_before = 1'b0;
         assign l_valid  = 1'b0;
         assign l_time   = req_time_ff;
         assign l_seq    = next_seq_ff;
         assign l_tag    = req_tag_ff;
      end else begin : g_left
         assign l_before = c_before[g-1];
         assign l_valid  = c_valid[g-1];
         assign l_time   = c_time[g-1];
         assign l_seq    = c_seq[g-1];
         assign l_tag    = c_tag[g-1];
      end

      // Past the tail the chain reads as an empty slot.
      if (g == QUEUE_DEPTH - 1) begin : g_tail
         assign r_valid = 1'b0;
         assign r_time  = req_time_ff;
         assign r_seq   = next_seq_ff;
         assign r_tag   = req_tag_ff;
      end else begin : g_right
         assign r_valid = c_valid[g+1];
         assign r_time  = c_time[g+1];
         assign r_seq   = c_seq[g+1];
         assign r_tag   = c_tag[g+1];
      end

      epq_cell #(
         .TIME_BITS (TIME_BITS),
         .TAG_BITS  (TAG_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .new_time    (req_time_ff),
         .new_seq     (next_seq_ff),
         .new_tag     (req_tag_ff),
         .left_before (l_before),
         .left_valid  (l_valid),
         .left_time   (l_time),
         .left_seq    (l_seq),
         .left_tag    (l_tag),
         .right_valid (r_valid),
         .right_time  (r_time),
         .right_seq   (r_seq),
         .right_tag   (r_tag),
         .new_before  (c_before[g]),
         .ent_valid   (c_valid[g]),
         .ent_time    (c_time[g]),
         .ent_seq     (c_seq[g]),
         .ent_tag     (c_tag[g])
      );
   end

endmodule

`default_nettype wire

/* hdl/epq_checker.sv */
// ----------------------------------------------------------------------------
// Event priority queue checker
// Port-level assertions on the event priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "event_priority_queue_macros.svh"

module epq_checker #(
   parameter int QUEUE_DEPTH   = epq_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int TIME_BITS     = epq_pkg::TIME_BITS_DEFAULT,
   parameter int TAG_BITS      = epq_pkg::TAG_BITS_DEFAULT,
   parameter int REQ_DATA_BITS = 56,
   parameter int RSP_DATA_BITS = 128
) (
   input wire                     clock,
   input wire                     reset,
   input wire                     req_tvalid,
   input wire                     req_tready,
   input wire [REQ_DATA_BITS-1:0] req_tdata,
   input wire                     rsp_tvalid,
   input wire                     rsp_tready,
   input wire [RSP_DATA_BITS-1:0] rsp_tdata
);

   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int COUNT_LSB  = epq_pkg::STATUS_BITS + TAG_BITS + TIME_BITS + epq_pkg::SEQ_BITS;

   logic                            req_fire;
   logic [epq_pkg::STATUS_BITS-1:0] rsp_status;
   logic [COUNT_BITS-1:0]           rsp_count;
   logic                            status_known;

   assign req_fire     = req_tvalid && req_tready && (req_tdata == req_tdata);
   assign rsp_status   = rsp_tdata[epq_pkg::STATUS_BITS-1:0];
   assign rsp_count    = rsp_tdata[COUNT_LSB +: COUNT_BITS];
   assign status_known = (rsp_status == epq_pkg::STATUS_OK) ||
                         (rsp_status == epq_pkg::STATUS_PAST) ||
                         (rsp_status == epq_pkg::STATUS_FULL) ||
                         (rsp_status == epq_pkg::STATUS_EMPTY) ||
                         (rsp_status == epq_pkg::STATUS_NOT_CURRENT);

   // A response held back by the consumer must not change.
   `EPQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   // Reset leaves no response pending.
   `EPQ_ASSERT_NEXT(a_reset_clear, clock, 1'b0, reset, !rsp_tvalid)
   // Each accepted request is worked on before the next one is taken.
   `EPQ_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_fire, !req_tready)
   // The reported fill never exceeds the chain length and the status is a defined code.
   `EPQ_ASSERT_NOW(a_rsp_sane, clock, reset, rsp_tvalid, status_known && (rsp_count <= COUNT_BITS'(QUEUE_DEPTH)))

endmodule

bind event_priority_queue epq_checker #(
   .QUEUE_DEPTH   (QUEUE_DEPTH),
   .TIME_BITS     (TIME_BITS),
   .TAG_BITS      (TAG_BITS),
   .REQ_DATA_BITS (REQ_DATA_BITS),
   .RSP_DATA_BITS (RSP_DATA_BITS)
) u_epq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

/* test/schedule_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event scheduler response checker
// Watches the request and response streams of the event priority queue,
// keeps its own copy of the scheduler state, works out the response that
// each accepted request must produce and compares every accepted response,
// field by field, with the oldest one still outstanding.
// ----------------------------------------------------------------------------

module schedule_checker #(
   parameter int QUEUE_DEPTH = epq_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int TIME_BITS   = epq_pkg::TIME_BITS_DEFAULT,
   parameter int TAG_BITS    = epq_pkg::TAG_BITS_DEFAULT,
   parameter int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1),
   parameter int REQ_W       = ((epq_pkg::CMD_BITS + TIME_BITS + TAG_BITS + 7) / 8) * 8,
   parameter int RSP_BITS    = epq_pkg::STATUS_BITS + TAG_BITS + 2 * TIME_BITS +
                               epq_pkg::SEQ_BITS + COUNT_BITS,
   parameter int RSP_W       = ((RSP_BITS + 7) / 8) * 8
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   input  wire                   req_tready,
   input  wire  [REQ_W-1:0]      req_tdata,
   input  wire                   rsp_tvalid,
   input  wire                   rsp_tready,
   input  wire  [RSP_W-1:0]      rsp_tdata,
   output int                    error_count,
   output int                    awaiting,
   output int                    requests_seen,
   output int                    rejects_seen,
   output int                    full_seen,
   output logic [TIME_BITS-1:0]  sched_now,
   output logic [COUNT_BITS-1:0] sched_held
);
   import epq_pkg::*;

   localparam int IDX_BITS = $clog2(QUEUE_DEPTH);

   // Packed structs put the first member in the top bits, so the members are
   // listed from the highest field of the response down to the status.
   typedef struct packed {
      logic [TIME_BITS-1:0]   now_t;
      logic [COUNT_BITS-1:0]  held;
      logic [SEQ_BITS-1:0]    seq_num;
      logic [TIME_BITS-1:0]   ev_time;
      logic [TAG_BITS-1:0]    tag;
      logic [STATUS_BITS-1:0] status;
   } sched_reply_type;

   logic [TIME_BITS-1:0]  slot_time [QUEUE_DEPTH];
   logic [SEQ_BITS-1:0]   slot_seq  [QUEUE_DEPTH];
   logic [TAG_BITS-1:0]   slot_tag  [QUEUE_DEPTH];
   logic [COUNT_BITS-1:0] held_n;
   logic [TIME_BITS-1:0]  cur_time;
   logic [SEQ_BITS-1:0]   next_seq;

   sched_reply_type pending_replies [$];

   assign sched_now  = cur_time;
   assign sched_held = held_n;

   initial begin
      error_count   = 0;
      awaiting      = 0;
      requests_seen = 0;
      rejects_seen  = 0;
      full_seen     = 0;
      held_n        = '0;
      cur_time      = '0;
      next_seq      = '0;
   end

   function automatic sched_reply_type predicted_reply(input logic [CMD_BITS-1:0] cmd,
                                                        input logic [TIME_BITS-1:0] ev_t,
                                                        input logic [TAG_BITS-1:0] ev_tag);
      sched_reply_type r;
      logic [IDX_BITS-1:0] best;
      logic [IDX_BITS-1:0] last;
      r = '0;
      r.status = STATUS_OK;
      case (cmd)
         CMD_SCHEDULE: begin
            // A time in the past is reported even when the queue is also full.
            if (ev_t < cur_time) begin
               r.status = STATUS_PAST;
            end else if (held_n >= QUEUE_DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               slot_time[held_n[IDX_BITS-1:0]] = ev_t;
               slot_seq[held_n[IDX_BITS-1:0]]  = next_seq;
               slot_tag[held_n[IDX_BITS-1:0]]  = ev_tag;
               r.tag     = ev_tag;
               r.ev_time = ev_t;
               r.seq_num = next_seq;
               next_seq  = next_seq + SEQ_BITS'(1);
               held_n    = held_n + COUNT_BITS'(1);
            end
         end
         CMD_POP: begin
            if (held_n == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               best = '0;
               for (int i = 1; i < held_n; i++)
                  if (slot_time[IDX_BITS'(i)] < slot_time[best] ||
                      (slot_time[IDX_BITS'(i)] == slot_time[best] &&
                       slot_seq[IDX_BITS'(i)] < slot_seq[best]))
                     best = IDX_BITS'(i);
               r.tag     = slot_tag[best];
               r.ev_time = slot_time[best];
               r.seq_num = slot_seq[best];
               // The slot that is freed takes the last held entry.
               last = IDX_BITS'(held_n - COUNT_BITS'(1));
               slot_time[best] = slot_time[last];
               slot_seq[best]  = slot_seq[last];
               slot_tag[best]  = slot_tag[last];
               held_n   = held_n - COUNT_BITS'(1);
               cur_time = r.ev_time;
            end
         end
         CMD_EXECUTE: begin
            if (ev_t != cur_time) begin
               r.status = STATUS_NOT_CURRENT;
            end else begin
               r.tag     = ev_tag;
               r.ev_time = ev_t;
               r.seq_num = next_seq;
               next_seq  = next_seq + SEQ_BITS'(1);
            end
         end
         default: ;
      endcase
      r.held  = held_n;
      r.now_t = cur_time;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      sched_reply_type seen;
      sched_reply_type want;
      if (reset) begin
         held_n   = '0;
         cur_time = '0;
         next_seq = '0;
         pending_replies.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen = sched_reply_type'(rsp_tdata[RSP_BITS-1:0]);
            if (pending_replies.size() == 0) begin
               $error("response with no request outstanding: %h", rsp_tdata);
               error_count++;
            end else begin
               want = pending_replies.pop_front();
               if (seen.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, seen.status);
                  error_count++;
               end
               if (seen.tag !== want.tag) begin
                  $error("out_tag: expected %h, got %h", want.tag, seen.tag);
                  error_count++;
               end
               if (seen.ev_time !== want.ev_time) begin
                  $error("out_time: expected %h, got %h", want.ev_time, seen.ev_time);
                  error_count++;
               end
               if (seen.seq_num !== want.seq_num) begin
                  $error("out_sequence: expected %0d, got %0d", want.seq_num, seen.seq_num);
                  error_count++;
               end
               if (seen.held !== want.held) begin
                  $error("queue_count: expected %0d, got %0d", want.held, seen.held);
                  error_count++;
               end
               if (seen.now_t !== want.now_t) begin
                  $error("now_time: expected %h, got %h", want.now_t, seen.now_t);
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            want = predicted_reply(req_tdata[CMD_BITS-1:0],
                                   req_tdata[CMD_BITS +: TIME_BITS],
                                   req_tdata[CMD_BITS + TIME_BITS +: TAG_BITS]);
            pending_replies.insert(pending_replies.size(), want);
            requests_seen++;
            if (want.status != STATUS_OK) rejects_seen++;
            if (want.status == STATUS_FULL) full_seen++;
         end
      end
      awaiting = pending_replies.size();
   end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event priority queue testbench
// Drives schedule, pop and execute-now requests into the queue: a short
// directed opening, a long random stretch that fills and drains the queue
// with mostly legal event times, and a closing pass at the top of the time
// range. The checker beside the block predicts and compares; this module
// makes the stimulus, throttles the response side and gives the verdict.
// ----------------------------------------------------------------------------

module tb_top;
   import epq_pkg::*;

   localparam int TIME_BITS       = TIME_BITS_DEFAULT;
   localparam int TAG_BITS        = TAG_BITS_DEFAULT;
   localparam int QUEUE_DEPTH     = QUEUE_DEPTH_DEFAULT;
   localparam int COUNT_BITS      = $clog2(QUEUE_DEPTH + 1);
   localparam int REQ_W           = ((CMD_BITS + TIME_BITS + TAG_BITS + 7) / 8) * 8;
   localparam int RSP_W           = ((STATUS_BITS + TAG_BITS + 2 * TIME_BITS + SEQ_BITS +
                                      COUNT_BITS + 7) / 8) * 8;
   localparam int RANDOM_REQUESTS = 1300;
   localparam int STALL_LIMIT     = 4000;
   localparam int HOLD_OFF_AFTER  = 1500;
   localparam int HOLD_OFF_SPAN   = 600;
   localparam logic [CMD_BITS-1:0]  CMD_UNUSED = 2'd3;
   localparam logic [TIME_BITS-1:0] TIME_MAX   = '1;
   localparam logic [TAG_BITS-1:0]  TAG_MAX    = '1;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             rsp_tready = 1'b0;
   wire              req_tready;
   wire              rsp_tvalid;
   wire  [RSP_W-1:0] rsp_tdata;

   int                    error_count;
   int                    awaiting;
   int                    requests_seen;
   int                    rejects_seen;
   int                    full_seen;
   logic [TIME_BITS-1:0]  sched_now;
   logic [COUNT_BITS-1:0] sched_held;

   // Back-to-back offering when set, random gaps otherwise.
   bit steady = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   event_priority_queue dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      // command, event_time, event_tag (lowest bits first)
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      // status, out_tag, out_time, out_sequence, queue_count, now_time (lowest bits first)
      .rsp_tdata  (rsp_tdata)
   );

   schedule_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .error_count   (error_count),
      .awaiting      (awaiting),
      .requests_seen (requests_seen),
      .rejects_seen  (rejects_seen),
      .full_seen     (full_seen),
      .sched_now     (sched_now),
      .sched_held    (sched_held)
   );

   // Offers one request and returns on the falling edge after its acceptance,
   // so that the predicted state already includes it when the next is chosen.
   task automatic issue(input logic [CMD_BITS-1:0] cmd, input logic [TIME_BITS-1:0] ev_t,
                        input logic [TAG_BITS-1:0] ev_tag);
      int gap;
      int roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 60) gap = 0;
      else if (roll < 92) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 40);
      @(posedge clock);
      repeat (gap) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {ev_tag, ev_t, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      req_tvalid <= 1'b0;
      @(negedge clock);
   endtask

   // Response side: random ready pattern, with one long hold-off so that the
   // block backs up and stalls its request input.
   initial begin : response_throttle
      int span;
      int cycles;
      bit held_off;
      cycles   = 0;
      held_off = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held_off && cycles >= HOLD_OFF_AFTER) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_SPAN) @(posedge clock);
            held_off = 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) < 70);
            if ($urandom_range(0, 9) == 0) span = $urandom_range(20, 80);
            else span = $urandom_range(1, 4);
            repeat (span) @(posedge clock);
            cycles += span;
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("Timeout: nothing accepted for %0d cycles", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : stimulus
      logic [CMD_BITS-1:0]   cmd;
      logic [TIME_BITS-1:0]  ev_t;
      logic [TAG_BITS-1:0]   ev_tag;
      logic [TIME_BITS-1:0]  now_v;
      logic [COUNT_BITS-1:0] held_v;
      bit filling;
      int pick;
      int sel;
      filling = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed opening: empty pop, execute at and away from time zero,
      // equal times resolved by order of arrival, an unused command code and
      // a schedule that lies in the past.
      issue(CMD_POP,      '0, '0);
      issue(CMD_EXECUTE,  '0, TAG_MAX);
      issue(CMD_EXECUTE,  5, 16'h0001);
      issue(CMD_SCHEDULE, '0, '0);
      issue(CMD_SCHEDULE, 100, 16'h1234);
      issue(CMD_SCHEDULE, 100, 16'h4321);
      issue(CMD_SCHEDULE, 7, 16'h00ff);
      issue(CMD_UNUSED,   TIME_MAX, TAG_MAX);
      issue(CMD_POP,      '0, '0);
      issue(CMD_POP,      '0, '0);
      issue(CMD_SCHEDULE, 3, 16'h5a5a);
      issue(CMD_POP,      '0, '0);
      issue(CMD_EXECUTE,  100, 16'habcd);
      issue(CMD_POP,      '0, '0);
      issue(CMD_POP,      '0, '0);

      // Random part: alternate between filling towards full and draining to
      // empty, with event times mostly at or ahead of the current time.
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 100 == 0) steady = ($urandom_range(0, 3) == 0);
         now_v  = sched_now;
         held_v = sched_held;
         if (filling && held_v == QUEUE_DEPTH && $urandom_range(0, 3) == 0) filling = 1'b0;
         else if (!filling && held_v == 0 && $urandom_range(0, 2) == 0) filling = 1'b1;
         pick   = $urandom_range(0, 99);
         sel    = $urandom_range(0, 9);
         ev_tag = TAG_BITS'($urandom);
         if (pick < 3) begin
            cmd  = CMD_UNUSED;
            ev_t = TIME_BITS'($urandom);
         end else if (pick < (filling ? 68 : 23)) begin
            cmd = CMD_SCHEDULE;
            if ((sel == 0 || (held_v == QUEUE_DEPTH && sel < 4)) && now_v != 0)
               ev_t = $urandom_range(0, now_v - 1);
            else if (sel < 4)
               ev_t = now_v + $urandom_range(0, 2);
            else
               ev_t = now_v + $urandom_range(0, 300);
         end else if (pick < 88) begin
            cmd  = CMD_POP;
            ev_t = TIME_BITS'($urandom);
         end else begin
            cmd = CMD_EXECUTE;
            if (sel < 8) ev_t = now_v;
            else if (sel == 8) ev_t = TIME_BITS'($urandom);
            else ev_t = now_v + 1'b1;
         end
         issue(cmd, ev_t, ev_tag);
      end

      // Closing pass at the top of the time range, which pins the current
      // time there for good.
      steady = 1'b0;
      while (sched_held != 0) issue(CMD_POP, TIME_BITS'($urandom), TAG_BITS'($urandom));
      issue(CMD_SCHEDULE, TIME_MAX, TAG_MAX);
      issue(CMD_EXECUTE,  TIME_MAX, 16'h8001);
      issue(CMD_POP,      '0, '0);
      issue(CMD_EXECUTE,  '0, 16'h7ffe);
      issue(CMD_SCHEDULE, '0, 16'h0f0f);
      issue(CMD_POP,      '0, '0);

      while (awaiting != 0) @(negedge clock);
      repeat (10) @(posedge clock);

      $display("Covered %0d requests, %0d of them rejected (%0d on a full queue),",
               requests_seen, rejects_seen, full_seen);
      $display("with random gaps on both sides and one long hold-off of the responses.");
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
